### design/ber_pkg.sv
`timescale 1ns / 1ps

package ber_pkg;

    localparam logic [7:0] PKT_ENTER  = 8'hF0;
    localparam logic [7:0] PKT_EXIT   = 8'hF1;
    localparam logic [7:0] PKT_SELECT = 8'hF2;
    localparam logic [7:0] PKT_RESET  = 8'hF3;

    localparam logic [7:0] MAGIC_LEN = 8'd21;

    typedef struct packed {
        logic [7:0] packet_type;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_packet;
    } ber_in_t;

    typedef struct packed {
        logic enumerating_now;
        logic bus_held;
        logic select_matched;
    } ber_out_t;

    function automatic logic [7:0] magic_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'hE6;
            5'd1:    b = 8'hAD;
            5'd2:    b = 8'hBB;
            5'd3:    b = 8'hE3;
            5'd4:    b = 8'h82;
            5'd5:    b = 8'h93;
            5'd6:    b = 8'hE3;
            5'd7:    b = 8'h81;
            5'd8:    b = 8'hA0;
            5'd9:    b = 8'hE4;
            5'd10:   b = 8'hB8;
            5'd11:   b = 8'h96;
            5'd12:   b = 8'hE7;
            5'd13:   b = 8'h95;
            5'd14:   b = 8'h8C;
            5'd15:   b = 8'hE6;
            5'd16:   b = 8'h88;
            5'd17:   b = 8'hA6;
            5'd18:   b = 8'hE7;
            5'd19:   b = 8'hB7;
            5'd20:   b = 8'h9A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### design/ber_core.sv
`timescale 1ns / 1ps

module ber_core #(
    parameter int ID_BYTES = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [63:0]      cfg_wr_data,
    input  logic             fire,
    input  ber_pkg::ber_in_t item,
    output ber_pkg::ber_out_t result
);

    localparam int IDX_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
    localparam logic [7:0] PAT_END  = 8'(ID_BYTES);
    localparam logic [7:0] MASK_END = 8'(2 * ID_BYTES);

    logic [63:0] device_id_reg;
    logic        enum_mode_reg, enum_mode_next;
    logic        hold_bus_reg, hold_bus_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic        magic_ok_reg, magic_ok_next;
    logic        id_mismatch_reg, id_mismatch_next;
    logic [7:0]  pattern_reg [ID_BYTES];

    logic [7:0]     cnt_take, cnt_eff;
    logic           mok_take, mok_eff;
    logic           mis_take, mis_eff;
    logic           last_eff;
    logic           pat_wr, mask_stage;
    logic [IDX_W-1:0] mis_idx;
    logic [7:0]     id_byte, pat_byte;
    logic           matched;

    always_comb begin
        pat_wr     = byte_count_reg < PAT_END;
        mask_stage = !pat_wr && (byte_count_reg < MASK_END);
        mis_idx    = IDX_W'(byte_count_reg - PAT_END);
        pat_byte   = pattern_reg[mis_idx];
        id_byte    = device_id_reg[{mis_idx, 3'b000} +: 8];

        mok_take = magic_ok_reg &&
                   ((byte_count_reg >= ber_pkg::MAGIC_LEN) ||
                    (item.data_byte == ber_pkg::magic_byte(byte_count_reg[4:0])));
        mis_take = id_mismatch_reg ||
                   (mask_stage && (|((pat_byte ^ id_byte) & item.data_byte)));
        cnt_take = (byte_count_reg == 8'hFF) ? byte_count_reg : byte_count_reg + 8'd1;

        if (item.empty_packet) begin
            cnt_eff  = 8'd0;
            mok_eff  = 1'b1;
            mis_eff  = 1'b0;
            last_eff = 1'b1;
        end else begin
            cnt_eff  = cnt_take;
            mok_eff  = mok_take;
            mis_eff  = mis_take;
            last_eff = item.last_byte;
        end
    end

    always_comb begin
        enum_mode_next   = enum_mode_reg;
        hold_bus_next    = hold_bus_reg;
        matched          = 1'b0;
        byte_count_next  = cnt_eff;
        magic_ok_next    = mok_eff;
        id_mismatch_next = mis_eff;
        if (last_eff) begin
            case (item.packet_type)
                ber_pkg::PKT_ENTER: begin
                    if (cnt_eff == ber_pkg::MAGIC_LEN && mok_eff) begin
                        enum_mode_next = 1'b1;
                        hold_bus_next  = 1'b1;
                    end
                end
                ber_pkg::PKT_EXIT: begin
                    if (enum_mode_reg) begin
                        enum_mode_next = 1'b0;
                        hold_bus_next  = 1'b0;
                    end
                end
                ber_pkg::PKT_RESET: begin
                    if (enum_mode_reg) begin
                        hold_bus_next = 1'b1;
                    end
                end
                ber_pkg::PKT_SELECT: begin
                    if (enum_mode_reg && (cnt_eff >= MASK_END) && !mis_eff) begin
                        matched       = 1'b1;
                        hold_bus_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            byte_count_next  = 8'd0;
            magic_ok_next    = 1'b1;
            id_mismatch_next = 1'b0;
        end
    end

    always_comb begin
        result.enumerating_now = enum_mode_next;
        result.bus_held        = hold_bus_next;
        result.select_matched  = matched;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_id_reg   <= 64'd0;
            enum_mode_reg   <= 1'b0;
            hold_bus_reg    <= 1'b0;
            byte_count_reg  <= 8'd0;
            magic_ok_reg    <= 1'b1;
            id_mismatch_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                device_id_reg <= cfg_wr_data;
            end
            if (fire) begin
                enum_mode_reg   <= enum_mode_next;
                hold_bus_reg    <= hold_bus_next;
                byte_count_reg  <= byte_count_next;
                magic_ok_reg    <= magic_ok_next;
                id_mismatch_reg <= id_mismatch_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && !item.empty_packet && pat_wr) begin
            pattern_reg[IDX_W'(byte_count_reg)] <= item.data_byte;
        end
    end

    hold_needs_enum: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_bus_reg |-> enum_mode_reg)
        else $error("bus held outside enumeration");

    count_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && last_eff |=> byte_count_reg == 8'd0 && magic_ok_reg && !id_mismatch_reg)
        else $error("packet state not cleared at packet end");

    match_only_select: assert property (@(posedge aclk) disable iff (!aresetn)
        matched |-> item.packet_type == ber_pkg::PKT_SELECT && enum_mode_reg)
        else $error("select match outside an enumerating select packet");

endmodule

### design/bus_enumeration_responder_unit.sv
`timescale 1ns / 1ps

// Enumeration responder: one packet payload byte per input transfer.
// Input channel s_valid/s_ready/s_data carries packet type, byte, end mark
// and empty flag; every input transfer yields exactly one result transfer on
// m_valid/m_ready/m_data (enumeration flag, bus hold, select match).
// device_id is written through cfg_wr_en/cfg_wr_data; the user must do so only while idle (not enforced).
// Pipeline: an input register, then the per-byte rule logic, then the
// result register. m_valid rises once an item has passed through both
// registers; throughput is one item per cycle unless the receiver stalls.
// When the receiver stalls, the result register holds, then the input
// register fills and s_ready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties both registers, clears the
// enumeration and bus-hold flags, zeroes device_id and starts a new packet.
// The pattern store has no reset; it is always written before it is read.
module bus_enumeration_responder_unit #(
    parameter int ID_BYTES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [63:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  ber_pkg::ber_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ber_pkg::ber_out_t  m_data
);

    logic               in_valid_reg;
    ber_pkg::ber_in_t   in_data_reg;
    logic               out_valid_reg;
    ber_pkg::ber_out_t  out_data_reg;
    ber_pkg::ber_out_t  core_result;
    logic               out_free;
    logic               fire;

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    ber_core #(
        .ID_BYTES(ID_BYTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .fire       (fire),
        .item       (in_data_reg),
        .result     (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= core_result;
        end
    end

    stalled_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a waiting transfer");

    match_drops_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.select_matched |->
            !out_data_reg.bus_held && out_data_reg.enumerating_now)
        else $error("select match without bus release");

    result_follows_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed transfer produced no result");

endmodule
